// File: hw/rtl/ldf_pkg.sv
// package for the length prefixed deframer
// holds widths, parser phase codes and the result record; depends on nothing
`default_nettype none

package ldf_pkg;

   localparam int LENGTH_BYTES = 3;
   localparam int DATA_W       = 8;
   localparam int LEN_W        = 8 * LENGTH_BYTES;
   localparam int HDR_IDX_W    = $clog2(LENGTH_BYTES + 1);

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_W-1:0] VERSION_RESET = 8'h01;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [DATA_W-1:0] body_byte;
      logic              last_of_frame;
      logic              empty_frame;
      logic              version_error;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/ldf_front.sv
// front part: takes stream bytes, tracks the frame header and body count
// and classifies each byte into a result record or none; uses ldf_pkg
`default_nettype none

module ldf_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          byte_valid,
   input  wire [ldf_pkg::DATA_W-1:0]    data_byte,
   input  wire                          csr_we,
   input  wire [ldf_pkg::DATA_W-1:0]    csr_wdata,
   output logic                         rec_valid,
   output ldf_pkg::rsp_type             rec
);

   ldf_pkg::phase_type                  phase_ff, phase_in;
   logic [ldf_pkg::HDR_IDX_W-1:0]       hdr_idx_ff, hdr_idx_in;
   logic [ldf_pkg::LEN_W-1:0]           accum_ff, accum_in;
   logic [ldf_pkg::LEN_W-1:0]           remain_ff, remain_in;
   logic [ldf_pkg::DATA_W-1:0]          version_ff;

   logic [ldf_pkg::LEN_W-1:0]           accum_shift;
   logic [ldf_pkg::LEN_W-1:0]           remain_dec;
   logic                                hdr_last;

   assign accum_shift = ldf_pkg::LEN_W'({accum_ff, data_byte});
   assign remain_dec  = remain_ff - ldf_pkg::LEN_W'(1);
   assign hdr_last    = (hdr_idx_ff == ldf_pkg::HDR_IDX_W'(ldf_pkg::LENGTH_BYTES));

   // next state
   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      accum_in   = accum_ff;
      remain_in  = remain_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            ldf_pkg::PH_HEADER: begin
               if (hdr_idx_ff == '0) begin
                  if (data_byte != version_ff) begin
                     phase_in = ldf_pkg::PH_ERROR;
                  end else begin
                     hdr_idx_in = ldf_pkg::HDR_IDX_W'(1);
                     accum_in   = '0;
                  end
               end else if (hdr_last) begin
                  hdr_idx_in = '0;
                  if (accum_shift == '0) begin
                     accum_in  = '0;
                     remain_in = '0;
                  end else begin
                     accum_in  = accum_shift;
                     remain_in = accum_shift;
                     phase_in  = ldf_pkg::PH_BODY;
                  end
               end else begin
                  accum_in   = accum_shift;
                  hdr_idx_in = hdr_idx_ff + ldf_pkg::HDR_IDX_W'(1);
               end
            end
            ldf_pkg::PH_BODY: begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  phase_in   = ldf_pkg::PH_HEADER;
                  hdr_idx_in = '0;
                  accum_in   = '0;
               end
            end
            default: begin
               phase_in = ldf_pkg::PH_ERROR;
            end
         endcase
      end
   end

   // result record for this byte
   always_comb begin
      rec_valid = 1'b0;
      rec       = '0;
      if (byte_valid) begin
         unique case (phase_ff)
            ldf_pkg::PH_HEADER: begin
               if (hdr_idx_ff == '0) begin
                  if (data_byte != version_ff) begin
                     rec_valid         = 1'b1;
                     rec.version_error = 1'b1;
                  end
               end else if (hdr_last && accum_shift == '0) begin
                  rec_valid         = 1'b1;
                  rec.last_of_frame = 1'b1;
                  rec.empty_frame   = 1'b1;
               end
            end
            ldf_pkg::PH_BODY: begin
               rec_valid         = 1'b1;
               rec.body_byte     = data_byte;
               rec.last_of_frame = (remain_dec == '0);
            end
            default: begin
               rec_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ldf_pkg::PH_HEADER;
         hdr_idx_ff <= '0;
         accum_ff   <= '0;
         remain_ff  <= '0;
         version_ff <= ldf_pkg::VERSION_RESET;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         accum_ff   <= accum_in;
         remain_ff  <= remain_in;
         if (csr_we) begin
            version_ff <= csr_wdata;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ldf_back.sv
// back part: short queue of result records that presents the oldest
// record to the result side; uses ldf_pkg
`default_nettype none

module ldf_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr_en,
   input  ldf_pkg::rsp_type    wr_rec,
   output logic                full,
   output logic                empty,
   input  wire                 pop,
   output ldf_pkg::rsp_type    head
);

   ldf_pkg::rsp_type              slot_ff [ldf_pkg::QUEUE_DEPTH];
   logic [ldf_pkg::QPTR_W-1:0]    wptr_ff, wptr_in;
   logic [ldf_pkg::QPTR_W-1:0]    rptr_ff, rptr_in;
   logic [ldf_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full    = (count_ff == ldf_pkg::QCNT_W'(ldf_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rptr_ff];
   assign do_push = wr_en;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + ldf_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + ldf_pkg::QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ldf_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - ldf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/length_prefixed_deframer.sv
// top level of the length prefixed deframer
// joins the parsing front (ldf_front) and the result queue (ldf_back); uses ldf_pkg
//
//   channel   ports                                   direction  handshake
//   req       req_push/req_full/req_data_byte         in         push while not full
//   rsp       rsp_pop/rsp_empty/rsp_* fields          out        pop while not empty
//   csr       csr_we/csr_wdata                        in         write enable, no wait
//
// one byte per clock is taken while req_full is low; a byte's result, if any,
// is in the queue the cycle after the byte is accepted
// the queue holds four records; req_full rises only when all four wait,
// so the input side keeps running while the result side stalls, up to that point
// synchronous active high reset: header phase, empty queue, version 1
// after a bad version byte the parser drops every byte until reset
`default_nettype none

module length_prefixed_deframer (
   input  wire                          clock,
   input  wire                          reset,
   // input stream
   input  wire                          req_push,
   output logic                         req_full,
   input  wire [ldf_pkg::DATA_W-1:0]    req_data_byte,
   // results
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic [ldf_pkg::DATA_W-1:0]   rsp_body_byte,
   output logic                         rsp_last_of_frame,
   output logic                         rsp_empty_frame,
   output logic                         rsp_version_error,
   // version register
   input  wire                          csr_we,
   input  wire [ldf_pkg::DATA_W-1:0]    csr_wdata
);

   logic               byte_valid;
   logic               rec_valid;
   ldf_pkg::rsp_type   rec;
   ldf_pkg::rsp_type   head;

   // an item is taken whenever the queue has room for its possible result
   assign byte_valid = req_push && !req_full;

   ldf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .data_byte  (req_data_byte),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   ldf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (rec_valid),
      .wr_rec (rec),
      .full   (req_full),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .head   (head)
   );

   // result fields straight from the queue head
   assign rsp_body_byte     = head.body_byte;
   assign rsp_last_of_frame = head.last_of_frame;
   assign rsp_empty_frame   = head.empty_frame;
   assign rsp_version_error = head.version_error;

endmodule

`default_nettype wire

// File: test/tb_top.sv
// testbench for length_prefixed_deframer: version/length framed byte stream in,
// body bytes and frame markers out, checked against an in-bench frame parser
// depends on ldf_pkg and the deframer rtl only
`timescale 1ns / 100ps

module tb_top;

   // one directed stimulus row: the byte, and an optional hand-written outcome
   typedef struct packed {
      logic [ldf_pkg::DATA_W-1:0] data;
      logic                       typed;
      logic                       has_rsp;
      ldf_pkg::rsp_type           rsp;
   } row_type;

   localparam ldf_pkg::rsp_type NO_RSP    = '0;
   localparam ldf_pkg::rsp_type EMPTY_RSP = '{body_byte: 8'h00, last_of_frame: 1'b1,
                                              empty_frame: 1'b1, version_error: 1'b0};
   localparam ldf_pkg::rsp_type ERROR_RSP = '{body_byte: 8'h00, last_of_frame: 1'b0,
                                              empty_frame: 1'b0, version_error: 1'b1};
   localparam ldf_pkg::rsp_type LAST_FF   = '{body_byte: 8'hff, last_of_frame: 1'b1,
                                              empty_frame: 1'b0, version_error: 1'b0};
   localparam int N_ROWS = 20;

   // dut ports, all inputs known from time zero
   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_push          = 1'b0;
   logic                       req_full;
   logic [ldf_pkg::DATA_W-1:0] req_data_byte     = '0;
   logic                       rsp_empty;
   logic                       rsp_pop           = 1'b0;
   logic [ldf_pkg::DATA_W-1:0] rsp_body_byte;
   logic                       rsp_last_of_frame;
   logic                       rsp_empty_frame;
   logic                       rsp_version_error;
   logic                       csr_we            = 1'b0;
   logic [ldf_pkg::DATA_W-1:0] csr_wdata         = '0;

   // outcome override for the item currently offered (directed rows only)
   logic                       row_typed   = 1'b0;
   logic                       row_has_rsp = 1'b0;
   ldf_pkg::rsp_type           row_rsp     = '0;

   // in-bench copy of the parser state and the version register
   ldf_pkg::phase_type            frm_phase;
   logic [ldf_pkg::HDR_IDX_W-1:0] hdr_idx;
   logic [ldf_pkg::LEN_W-1:0]     len_acc;
   logic [ldf_pkg::LEN_W-1:0]     body_left;
   logic [ldf_pkg::DATA_W-1:0]    version_reg;

   ldf_pkg::rsp_type due_records [$];  // records the dut still owes, oldest first

   int send_idle = 0;         // percent of cycles the sender holds back
   int recv_idle = 0;         // percent of cycles the receiver holds back
   int n_fail    = 0;
   int n_bytes   = 0;
   int n_records = 0;
   int n_frames  = 0;
   logic [ldf_pkg::DATA_W-1:0] last_version;

   // directed rows: empty frame at the reset version, one-byte frame,
   // body extremes, then back-to-back empty frame
   row_type dir_rows [N_ROWS] = '{
      '{8'h01, 1'b1, 1'b0, NO_RSP},     // version byte at reset value
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, EMPTY_RSP},  // zero length ends the frame at once
      '{8'h01, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h01, 1'b1, 1'b0, NO_RSP},
      '{8'hff, 1'b1, 1'b1, LAST_FF},    // single body byte is also the last
      '{8'h01, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h03, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},     // body bytes go through the parser model
      '{8'h7f, 1'b0, 1'b0, NO_RSP},
      '{8'h80, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, EMPTY_RSP}
   };

   length_prefixed_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame),
      .rsp_version_error (rsp_version_error),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // back to the start of a header
   function automatic void restart_header();
      frm_phase = ldf_pkg::PH_HEADER;
      hdr_idx   = '0;
      len_acc   = '0;
      body_left = '0;
   endfunction

   // parser model: feeds one byte, returns 1 when it yields a record
   function automatic bit deframe_byte(input logic [ldf_pkg::DATA_W-1:0] b,
                                       output ldf_pkg::rsp_type r);
      r = NO_RSP;
      case (frm_phase)
         ldf_pkg::PH_HEADER: begin
            // version byte: compare, or halt for good
            if (hdr_idx == '0) begin
               if (b != version_reg) begin
                  frm_phase       = ldf_pkg::PH_ERROR;
                  r.version_error = 1'b1;
                  return 1'b1;
               end
               hdr_idx = ldf_pkg::HDR_IDX_W'(1);
               len_acc = '0;
               return 1'b0;
            end
            // big-endian length, used only once every byte is in
            len_acc = (len_acc << ldf_pkg::DATA_W) | ldf_pkg::LEN_W'(b);
            if (hdr_idx >= ldf_pkg::LENGTH_BYTES) begin
               if (len_acc == '0) begin
                  restart_header();
                  r.last_of_frame = 1'b1;
                  r.empty_frame   = 1'b1;
                  return 1'b1;
               end
               body_left = len_acc;
               frm_phase = ldf_pkg::PH_BODY;
               hdr_idx   = '0;
               return 1'b0;
            end
            hdr_idx = hdr_idx + 1'b1;
            return 1'b0;
         end
         ldf_pkg::PH_BODY: begin
            body_left   = body_left - 1'b1;
            r.body_byte = b;
            if (body_left == '0) begin
               restart_header();
               r.last_of_frame = 1'b1;
            end
            return 1'b1;
         end
         default: return 1'b0;  // halted after a bad version, or an unused code
      endcase
   endfunction

   // receiver: pops at random, never during reset
   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // scoreboard: checks popped records, predicts on accepted bytes,
   // tracks register writes; all samples are pre-edge values
   always @(posedge clock) begin : scoreboard
      ldf_pkg::rsp_type got;
      ldf_pkg::rsp_type want;
      ldf_pkg::rsp_type pred;
      bit               has;
      if (reset) begin
         version_reg = ldf_pkg::VERSION_RESET;
         restart_header();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{body_byte: rsp_body_byte, last_of_frame: rsp_last_of_frame,
                    empty_frame: rsp_empty_frame, version_error: rsp_version_error};
            n_records++;
            if (got.last_of_frame === 1'b1) n_frames++;
            if (due_records.size() == 0) begin
               if (n_fail < 10)
                  $display("%0t: record with nothing due: byte %02h last %b empty %b err %b",
                           $realtime, got.body_byte, got.last_of_frame, got.empty_frame,
                           got.version_error);
               n_fail++;
            end else begin
               want = due_records.pop_front();
               if (got.body_byte !== want.body_byte
                   || got.last_of_frame !== want.last_of_frame
                   || got.empty_frame !== want.empty_frame
                   || got.version_error !== want.version_error) begin
                  if (n_fail < 10)
                     $display("%0t: record %0d want %02h %b %b %b, got %02h %b %b %b",
                              $realtime, n_records, want.body_byte, want.last_of_frame,
                              want.empty_frame, want.version_error, got.body_byte,
                              got.last_of_frame, got.empty_frame, got.version_error);
                  n_fail++;
               end
            end
         end
         if (req_push && !req_full) begin
            // model always advances; a typed row overrides its outcome
            has = deframe_byte(req_data_byte, pred);
            if (row_typed) begin
               has  = row_has_rsp;
               pred = row_rsp;
            end
            if (has) due_records = {due_records, pred};
            n_bytes++;
         end
         if (csr_we) version_reg = csr_wdata;
      end
   end

   // offer one byte, with random idle cycles ahead of it; returns in the
   // time step of the edge that took it
   task automatic push_byte(input logic [ldf_pkg::DATA_W-1:0] b, input logic typed,
                            input logic has_rsp, input ldf_pkg::rsp_type r);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      row_typed     <= typed;
      row_has_rsp   <= has_rsp;
      row_rsp       <= r;
      do @(posedge clock); while (req_full);
   endtask

   // stop sending, let every owed record drain and idle a while,
   // then write the version register
   task automatic write_version(input logic [ldf_pkg::DATA_W-1:0] v);
      req_push <= 1'b0;
      while (due_records.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      last_version = v;
   endtask

   // well-formed frames with random bodies, mostly short lengths,
   // some empty, a few long enough to use the middle length byte
   task automatic push_frames(input logic [ldf_pkg::DATA_W-1:0] ver, input int budget);
      int                        sent;
      int                        pick;
      logic [ldf_pkg::LEN_W-1:0] len;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 10)      len = '0;
         else if (pick < 94) len = ldf_pkg::LEN_W'($urandom_range(12, 1));
         else                len = ldf_pkg::LEN_W'($urandom_range(400, 13));
         push_byte(ver, 1'b0, 1'b0, NO_RSP);
         for (int i = ldf_pkg::LENGTH_BYTES - 1; i >= 0; i--)
            push_byte(len[i*ldf_pkg::DATA_W +: ldf_pkg::DATA_W], 1'b0, 1'b0, NO_RSP);
         for (int i = 0; i < len; i++)
            push_byte(ldf_pkg::DATA_W'($urandom), 1'b0, 1'b0, NO_RSP);
         sent += 1 + ldf_pkg::LENGTH_BYTES + int'(len);
      end
   endtask

   // main sequence
   initial begin : stimulus
      logic [ldf_pkg::DATA_W-1:0] ver;
      last_version = ldf_pkg::VERSION_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset version; sender idles 20, receiver 52
      send_idle = 20;
      recv_idle = 52;
      foreach (dir_rows[i])
         push_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].has_rsp,
                   dir_rows[i].rsp);

      // lowest version, same idling
      write_version(8'h00);
      push_frames(8'h00, 620);

      // highest version, idling swapped
      send_idle = 52;
      recv_idle = 20;
      write_version(8'hff);
      push_frames(8'hff, 620);

      // random version, no idling on either side
      send_idle = 0;
      recv_idle = 0;
      ver = ldf_pkg::DATA_W'($urandom_range(254, 1));
      write_version(ver);
      push_frames(ver, 620);

      // bad version halts the parser; everything after it is dropped
      push_byte(~ver, 1'b1, 1'b1, ERROR_RSP);
      repeat (16) push_byte(ldf_pkg::DATA_W'($urandom), 1'b0, 1'b0, NO_RSP);
      req_push <= 1'b0;

      // drain, then wait a while for anything stray to show up
      while (due_records.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      n_fail += due_records.size();

      $display("run: %0d bytes in, %0d records out, %0d frames closed", n_bytes,
               n_records, n_frames);
      $display("run: versions 01, 00, ff, %02h; idling both ways; halt on bad version",
               last_version);
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", n_fail);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d records still due", due_records.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_front.sv
hw/rtl/ldf_back.sv
hw/rtl/length_prefixed_deframer.sv
test/tb_top.sv
